FILE: hw/rtl/bram9_pkg.sv
// ----------------------------------------------------------------------------
// bram9_pkg: shared types and constants of the banked RAM mapper
// Holds the item structs, request codes, controller states, the command and
// status bundles between controller and datapath, and the memory geometry.
// ----------------------------------------------------------------------------
package bram9_pkg;

    // Memory geometry.
    localparam int RAM_BYTES      = 131072;
    localparam int RAM_ADDR_BITS  = $clog2(RAM_BYTES);
    localparam int BANK_ADDR_BITS = 13;
    localparam int CPU_ADDR_BITS  = 16;
    localparam int BANK_BITS      = 4;
    localparam int BANK_ENTRIES   = 16;
    localparam int PHYS_BITS      = 17;
    localparam int HALF_WINDOW    = 1 << (BANK_ADDR_BITS - 1);

    typedef logic [BANK_BITS-1:0]          t_bank;
    typedef logic [$clog2(BANK_ENTRIES)-1:0] t_bank_idx;
    typedef logic [RAM_ADDR_BITS-1:0]      t_ram_addr;
    typedef logic [PHYS_BITS-1:0]          t_phys;
    typedef logic [CPU_ADDR_BITS-1:0]      t_cpu_addr;

    // Bank table contents after reset: identity for the low 64K, then zeros.
    localparam t_bank BANK_RESET [BANK_ENTRIES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    // Top nibbles of the CPU address that mark the special areas.
    localparam logic [3:0] IO_PAGE    = 4'hC;
    localparam logic [3:0] UPPER_PAGE = 4'hD;

    // Upper mode: reset value, write-only and no-access codes of bits 1..0, read-back fill.
    localparam logic [3:0] MODE_RESET      = 4'h1;
    localparam logic [1:0] MODE_WRITE_ONLY = 2'b01;
    localparam logic [1:0] MODE_NO_ACCESS  = 2'b00;
    localparam logic [3:0] MODE_READ_FILL  = 4'hF;

    typedef enum logic [2:0] {
        REQ_MEM_RD  = 3'd0,
        REQ_MEM_WR  = 3'd1,
        REQ_MAP_RD  = 3'd2,
        REQ_MAP_WR  = 3'd3,
        REQ_MODE_RD = 3'd4,
        REQ_MODE_WR = 3'd5
    } t_req;

    typedef struct packed {
        logic [2:0]  req_type;
        t_cpu_addr   cpu_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_driven;
        t_phys       physical_address;
        logic        byte_changed;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic lookup;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/bram9_ctrl.sv
// ----------------------------------------------------------------------------
// bram9_ctrl: sequencing controller of the banked RAM mapper
// Runs the RAM clearing pass after reset, then steps each item through
// accept, lookup and finish, holding in finish while the output is full.
// ----------------------------------------------------------------------------
module bram9_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bram9_pkg::t_status i_status,
    output bram9_pkg::t_cmd    o_cmd
);

    bram9_pkg::t_state r_state;
    bram9_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bram9_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            bram9_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = bram9_pkg::ST_IDLE;
                end
            end
            bram9_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bram9_pkg::ST_LOOKUP;
                end
            end
            bram9_pkg::ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = bram9_pkg::ST_FINISH;
            end
            bram9_pkg::ST_FINISH: begin
                // The result may only enter the output register once it is free.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = bram9_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bram9_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/bram9_datapath.sv
// ----------------------------------------------------------------------------
// bram9_datapath: translation, RAM and result logic of the banked RAM mapper
// Holds the request register, bank table, mode register, the RAM array with
// its registered read, the clear counter and the output register.
// ----------------------------------------------------------------------------
module bram9_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bram9_pkg::t_cmd      i_cmd,
    output bram9_pkg::t_status   o_status,
    input  bram9_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bram9_pkg::t_out_item o_out_item
);

    bram9_pkg::t_in_item  r_req;
    bram9_pkg::t_bank     r_bank [bram9_pkg::BANK_ENTRIES];
    logic [3:0]           r_mode;
    logic [7:0]           r_mem [bram9_pkg::RAM_BYTES];
    logic [7:0]           r_ram_q;
    bram9_pkg::t_ram_addr r_phys;
    bram9_pkg::t_ram_addr r_clr_addr;
    logic                 r_out_valid;
    bram9_pkg::t_out_item r_out;

    logic                 is_mem;
    logic                 is_io;
    logic                 is_upper;
    logic                 enabled;
    logic                 served;
    bram9_pkg::t_cpu_addr eff_addr;
    bram9_pkg::t_bank_idx map_idx;
    bram9_pkg::t_bank_idx tbl_idx;
    bram9_pkg::t_bank     tbl_q;
    bram9_pkg::t_phys     phys_full;
    bram9_pkg::t_ram_addr phys_idx;
    logic                 do_write;
    logic                 ram_we;
    bram9_pkg::t_ram_addr ram_waddr;
    logic [7:0]           ram_wdata;
    bram9_pkg::t_out_item result;

    // Request decode. Both the window index and the map index go through a
    // single read port of the bank table.
    always_comb begin
        is_mem   = (r_req.req_type == bram9_pkg::REQ_MEM_RD) ||
                   (r_req.req_type == bram9_pkg::REQ_MEM_WR);
        is_io    = r_req.cpu_address[15:12] == bram9_pkg::IO_PAGE;
        is_upper = r_req.cpu_address[15:12] >= bram9_pkg::UPPER_PAGE;
        served   = is_mem && !is_io;
        if (!is_upper) begin
            enabled = 1'b1;
        end else if (r_req.req_type == bram9_pkg::REQ_MEM_RD) begin
            enabled = r_mode[1:0] != bram9_pkg::MODE_WRITE_ONLY;
        end else begin
            enabled = r_mode[0];
        end
        // D000-DFFF folds onto the low half of window six unless mode bit 3 is set.
        if ((r_req.cpu_address[15:12] == bram9_pkg::UPPER_PAGE) && !r_mode[3]) begin
            eff_addr = r_req.cpu_address - bram9_pkg::t_cpu_addr'(bram9_pkg::HALF_WINDOW);
        end else begin
            eff_addr = r_req.cpu_address;
        end
        map_idx   = r_req.cpu_address[7:4];
        tbl_idx   = is_mem ? bram9_pkg::t_bank_idx'(
                        eff_addr[bram9_pkg::CPU_ADDR_BITS-1:bram9_pkg::BANK_ADDR_BITS])
                           : map_idx;
        tbl_q     = r_bank[tbl_idx];
        phys_full = {tbl_q, eff_addr[bram9_pkg::BANK_ADDR_BITS-1:0]};
        phys_idx  = phys_full[bram9_pkg::RAM_ADDR_BITS-1:0];
    end

    // Finish step: form the result and decide on the RAM write.
    always_comb begin
        result   = '0;
        do_write = 1'b0;
        case (bram9_pkg::t_req'(r_req.req_type))
            bram9_pkg::REQ_MEM_RD: begin
                if (served) begin
                    result.physical_address = bram9_pkg::t_phys'(r_phys);
                    if (enabled) begin
                        result.read_data   = r_ram_q;
                        result.read_driven = 1'b1;
                    end
                end
            end
            bram9_pkg::REQ_MEM_WR: begin
                if (served) begin
                    result.physical_address = bram9_pkg::t_phys'(r_phys);
                    do_write            = enabled && (r_ram_q != r_req.write_data);
                    result.byte_changed = do_write;
                end
            end
            bram9_pkg::REQ_MAP_RD: begin
                result.read_data   = {map_idx, tbl_q};
                result.read_driven = 1'b1;
            end
            bram9_pkg::REQ_MODE_RD: begin
                result.read_data = {bram9_pkg::MODE_READ_FILL, r_mode};
                if (r_mode[1:0] == bram9_pkg::MODE_NO_ACCESS) begin
                    result.read_data[1] = 1'b1;
                end
                result.read_driven = 1'b1;
            end
            default: begin
                result = '0;
            end
        endcase
    end

    assign ram_we    = i_cmd.clear_en || (i_cmd.finish && do_write);
    assign ram_waddr = i_cmd.clear_en ? r_clr_addr : r_phys;
    assign ram_wdata = i_cmd.clear_en ? 8'h00 : r_req.write_data;

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_mem[ram_waddr] <= ram_wdata;
        end
        if (i_cmd.lookup) begin
            r_ram_q <= r_mem[phys_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_item;
        end
        if (i_cmd.lookup) begin
            r_phys <= phys_idx;
        end
        if (i_cmd.finish) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bram9_pkg::BANK_ENTRIES; i++) begin
                r_bank[i] <= bram9_pkg::BANK_RESET[i];
            end
            r_mode      <= bram9_pkg::MODE_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish && (r_req.req_type == bram9_pkg::REQ_MAP_WR)) begin
                r_bank[map_idx] <= r_req.cpu_address[3:0];
            end
            if (i_cmd.finish && (r_req.req_type == bram9_pkg::REQ_MODE_WR)) begin
                r_mode <= r_req.cpu_address[3:0];
            end
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clear_last = &r_clr_addr;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out;

endmodule

FILE: hw/rtl/banked_ram_mapper_9_unit.sv
// ----------------------------------------------------------------------------
// banked_ram_mapper_9_unit: native-mode memory manager for 128K of RAM
// Translates CPU accesses through a 16-entry bank table and an upper-area
// mode register, serves map and mode accesses, and reports write changes.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole RAM to zero, one byte per cycle, and
// holds o_in_stall high until that pass ends, before it takes its first item.
// From then on each item passes through the cycle it is accepted, a
// lookup cycle in which the bank table translates the address and the RAM
// read is issued, and a finish cycle in which the registered RAM byte is
// compared with the write data, the RAM, bank table or mode register is
// updated and the result enters the output register. Because the RAM read
// is followed by the compare-and-write of that byte, a new item is taken only
// after the last one has finished. The output register lets the next item be
// accepted while a result still waits; only when a finished result finds the
// output register still full does the block hold in finish.
// Reads of disabled areas and of the I/O page come back with read_driven low.
// ----------------------------------------------------------------------------
module banked_ram_mapper_9_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bram9_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bram9_pkg::t_out_item o_out_item
);

    bram9_pkg::t_cmd    w_cmd;
    bram9_pkg::t_status w_status;

    // The controller only sequences; all state that the items touch lives in
    // the datapath.
    bram9_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bram9_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // The controller issues at most one command in any cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear_en, w_cmd.accept, w_cmd.lookup, w_cmd.finish}))
        else $error("more than one command in a cycle");

    // No item is taken while the RAM is being cleared.
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_en |-> o_in_stall)
        else $error("item accepted during clearing pass");

    // An accepted item is looked up in the very next cycle.
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_cmd.lookup)
        else $error("accepted item not looked up");

    // A result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten before it was taken");

    // A result only appears after a finish step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("output valid without a finish step");

endmodule
